// ===== rtl/led_pixel_buffer_order_scale_unit_defines.svh =====
// Assertion macros for the LED pixel buffer unit.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef LED_PIXEL_BUFFER_ORDER_SCALE_UNIT_DEFINES_SVH
`define LED_PIXEL_BUFFER_ORDER_SCALE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle property check, disabled while in reset
`define LPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication check, disabled while in reset
`define LPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LPB_ASSERT(lbl, prop, msg)
`define LPB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lpbos_pkg.sv =====
// Package for the LED pixel buffer unit: sizes, codes, result type and
// byte helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lpbos_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] MAX_PIX_CNT = CNT_W'(MAX_PIXELS);

  // Register reset values
  localparam logic [7:0]       COLOR_ORDER_RST = 8'd82;
  localparam logic [CNT_W-1:0] PIXEL_COUNT_RST = 7'd16;
  localparam logic [7:0]       BRIGHTNESS_RST  = 8'd0;

  localparam logic [7:0] BYTE_MAX = 8'hFF;
  localparam logic [1:0] LANE_MASK = 2'b11;

  // Channel slots, numbered by position in the packed colour
  localparam int CH_B = 0;
  localparam int CH_G = 1;
  localparam int CH_R = 2;
  localparam int CH_W = 3;

  localparam int DIV_STEPS = 8;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_READ  = 1'b1
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_COLOR_ORDER = 2'd0,
    CFG_PIXEL_COUNT = 2'd1,
    CFG_BRIGHTNESS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_DIV,
    ST_RDONE,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] byte_offset;
    logic [8:0]  byte_count;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [31:0] packed_color;
  } res_t;

  // Byte of a slot at a device lane
  function automatic logic [7:0] get_byte(input logic [31:0] slot, input logic [1:0] lane);
    logic [31:0] sh;
    sh = slot >> {lane & LANE_MASK, 3'b000};
    return sh[7:0];
  endfunction

  // Replace one byte of a slot
  function automatic logic [31:0] put_byte(input logic [31:0] slot, input logic [1:0] lane,
                                           input logic [7:0] v);
    logic [31:0] mask;
    mask = {24'b0, BYTE_MAX} << {lane & LANE_MASK, 3'b000};
    return (slot & ~mask) | ({24'b0, v} << {lane & LANE_MASK, 3'b000});
  endfunction

  // x*b>>8, or x untouched when brightness is zero
  function automatic logic [7:0] scale_down(input logic [7:0] x, input logic [7:0] b);
    logic [15:0] prod;
    prod = {8'b0, x} * {8'b0, b};
    return (b == 8'd0) ? x : prod[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/led_pixel_buffer_order_scale_unit.sv =====
// LED pixel buffer with colour-order mapping and brightness scaling; uses lpbos_pkg.
// Path from acceptance to registered result: write via ST_WR, clear via ST_CLR,
// out-of-range read via ST_RDONE, in-range read via ST_RD, then ST_DIV (8-step
// divider) unless brightness is 0, then ST_RDONE. One request in flight, input
// stalled while busy or held by out_stall; out-of-range writes give no result.
// Reset (synchronous, rst_n low): registers to defaults, pixel valid flags cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "led_pixel_buffer_order_scale_unit_defines.svh"
module led_pixel_buffer_order_scale_unit
  import lpbos_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_pixel_index,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_white,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [15:0]      out_byte_offset,
  output logic [8:0]       out_byte_count,
  output logic [7:0]       out_byte_zero,
  output logic [7:0]       out_byte_one,
  output logic [7:0]       out_byte_two,
  output logic [7:0]       out_byte_three,
  output logic [31:0]      out_packed_color
);

  // Configuration registers
  logic [7:0]       color_order_r;
  logic [CNT_W-1:0] pixel_count_r;
  logic [7:0]       brightness_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_order_r <= COLOR_ORDER_RST;
      pixel_count_r <= PIXEL_COUNT_RST;
      brightness_r  <= BRIGHTNESS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_COLOR_ORDER: color_order_r <= cfg_data;
        CFG_PIXEL_COUNT: pixel_count_r <= cfg_data[CNT_W-1:0];
        CFG_BRIGHTNESS:  brightness_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoded configuration
  logic [1:0]       lane [4];
  logic             rgb_mode;
  logic [CNT_W-1:0] used_pixels;
  logic [2:0]       bpp;

  assign lane[CH_W]  = color_order_r[7:6];
  assign lane[CH_R]  = color_order_r[5:4];
  assign lane[CH_G]  = color_order_r[3:2];
  assign lane[CH_B]  = color_order_r[1:0];
  assign rgb_mode    = (lane[CH_W] == lane[CH_R]);
  assign used_pixels = (pixel_count_r > MAX_PIX_CNT) ? MAX_PIX_CNT : pixel_count_r;
  assign bpp         = rgb_mode ? 3'd3 : 3'd4;

  // Control state
  state_t             state_r, state_nxt;
  logic [DIV_CW-1:0]  div_cnt_r;
  logic               out_valid_r;
  res_t               out_res_r;
  logic [MAX_PIXELS-1:0] valid_r;

  logic accept, in_range, out_free;
  logic out_load, mem_re, mem_we, valid_clr;
  res_t res_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (in_pixel_index < 16'(used_pixels));
  assign out_free = !out_valid_r || !out_stall;

  // Datapath registers
  logic [PIX_AW-1:0] idx_r;
  logic [7:0]        sc_r   [4];
  logic [7:0]        rem_r  [4];
  logic [7:0]        quot_r [4];
  logic [3:0]        sat_r;

  // Pixel store
  logic [31:0] mem [MAX_PIXELS];
  logic [31:0] rdata_r;
  logic [31:0] slot_cur;
  logic [31:0] wr_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= wr_slot;
    end
    if (mem_re) begin
      rdata_r <= mem[in_pixel_index[PIX_AW-1:0]];
    end
  end

  // Unwritten or cleared entries read as zero
  assign slot_cur = valid_r[idx_r] ? rdata_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || valid_clr) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  // Merge scaled components into the slot, W first (skipped in RGB mode), B last
  logic [31:0] m_w, m_r, m_g;
  always_comb begin
    m_w     = rgb_mode ? slot_cur : put_byte(slot_cur, lane[CH_W], sc_r[CH_W]);
    m_r     = put_byte(m_w, lane[CH_R], sc_r[CH_R]);
    m_g     = put_byte(m_r, lane[CH_G], sc_r[CH_G]);
    wr_slot = put_byte(m_g, lane[CH_B], sc_r[CH_B]);
  end

  // Result candidates
  res_t wr_res, rd_res, clr_res;
  logic [7:0] rd_comp [4];
  logic [9:0] clr_len;

  always_comb begin
    wr_res              = '0;
    wr_res.result_kind  = RES_WRITE;
    wr_res.byte_offset  = rgb_mode ? (16'({idx_r, 1'b0}) + 16'(idx_r)) : 16'({idx_r, 2'b00});
    wr_res.byte_count   = 9'(bpp);
    wr_res.byte_zero    = wr_slot[7:0];
    wr_res.byte_one     = wr_slot[15:8];
    wr_res.byte_two     = wr_slot[23:16];
    wr_res.byte_three   = rgb_mode ? 8'd0 : wr_slot[31:24];

    for (int i = 0; i < 4; i++) begin
      rd_comp[i] = sat_r[i] ? BYTE_MAX : quot_r[i];
    end
    rd_res              = '0;
    rd_res.result_kind  = RES_READ;
    rd_res.packed_color = {rgb_mode ? 8'd0 : rd_comp[CH_W], rd_comp[CH_R],
                           rd_comp[CH_G], rd_comp[CH_B]};

    clr_len             = 10'(used_pixels) * 10'(bpp);
    clr_res             = '0;
    clr_res.result_kind = RES_WRITE;
    clr_res.byte_count  = clr_len[8:0];
  end

  // Next state and control
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    res_nxt   = wr_res;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    valid_clr = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_WRITE: begin
              if (in_range) begin
                mem_re    = 1'b1;
                state_nxt = ST_WR;
              end
            end
            KIND_READ: begin
              mem_re    = in_range;
              state_nxt = in_range ? ST_RD : ST_RDONE;
            end
            KIND_CLEAR: begin
              valid_clr = 1'b1;
              state_nxt = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_WR: begin
        if (out_free) begin
          mem_we    = 1'b1;
          out_load  = 1'b1;
          res_nxt   = wr_res;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = (brightness_r == 8'd0) ? ST_RDONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          state_nxt = ST_RDONE;
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_nxt   = rd_res;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_nxt   = clr_res;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, divider counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end else begin
        div_cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot bytes per channel, and one restoring-division step per lane
  logic [7:0] rd_byte  [4];
  logic [8:0] rem2     [4];
  logic [3:0] step_ge;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_byte[i] = get_byte(slot_cur, lane[i]);
      rem2[i]    = {rem_r[i], 1'b0};
      step_ge[i] = (rem2[i] >= {1'b0, brightness_r});
    end
  end

  // Datapath: request capture, read setup, divider iterations
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r      <= in_pixel_index[PIX_AW-1:0];
      sc_r[CH_W] <= scale_down(in_white, brightness_r);
      sc_r[CH_R] <= scale_down(in_red, brightness_r);
      sc_r[CH_G] <= scale_down(in_green, brightness_r);
      sc_r[CH_B] <= scale_down(in_blue, brightness_r);
      sat_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        quot_r[i] <= 8'd0;
      end
    end else if (state_r == ST_RD) begin
      for (int i = 0; i < 4; i++) begin
        rem_r[i] <= rd_byte[i];
        if (brightness_r == 8'd0) begin
          quot_r[i] <= rd_byte[i];
          sat_r[i]  <= 1'b0;
        end else begin
          quot_r[i] <= 8'd0;
          sat_r[i]  <= (rd_byte[i] >= brightness_r);
        end
      end
    end else if (state_r == ST_DIV) begin
      for (int i = 0; i < 4; i++) begin
        rem_r[i]  <= step_ge[i] ? 8'(rem2[i] - {1'b0, brightness_r}) : rem2[i][7:0];
        quot_r[i] <= {quot_r[i][6:0], step_ge[i]};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.result_kind;
  assign out_byte_offset  = out_res_r.byte_offset;
  assign out_byte_count   = out_res_r.byte_count;
  assign out_byte_zero    = out_res_r.byte_zero;
  assign out_byte_one     = out_res_r.byte_one;
  assign out_byte_two     = out_res_r.byte_two;
  assign out_byte_three   = out_res_r.byte_three;
  assign out_packed_color = out_res_r.packed_color;

  // Checks
  `LPB_ASSERT_NEXT(a_wr_done, (state_r == ST_WR) && out_free,
                   (state_r == ST_IDLE) && out_valid_r, "write did not complete")
  `LPB_ASSERT_NEXT(a_div_runs, (state_r == ST_DIV) && (div_cnt_r != DIV_CW'(DIV_STEPS - 1)),
                   state_r == ST_DIV, "divider left early")
  `LPB_ASSERT_NEXT(a_clear_flags, accept && (in_kind == KIND_CLEAR), valid_r == '0,
                   "clear left valid flags set")
  `LPB_ASSERT(a_read_fields,
              (out_valid_r && (out_res_r.result_kind == RES_READ)) |->
              ((out_res_r.byte_count == 9'd0) && (out_res_r.byte_offset == 16'd0)),
              "read result with write fields")

endmodule
`default_nettype wire
